// ===== design/swc_pkg.sv =====
// Shared types, constants and the divide-by-slew-rate digit step for the slewed wall clock.
package swc_pkg;

  // Operation codes carried by an item.
  typedef enum logic [1:0] {
    FN_READ = 2'd0,
    FN_INIT = 2'd1,
    FN_SET  = 2'd2,
    FN_SLEW = 2'd3
  } swc_func_t;

  localparam int unsigned CORR_PPM   = 500;
  localparam int unsigned PPM_SCALE  = 1000000;
  localparam int unsigned SLEW_DIV   = PPM_SCALE / CORR_PPM;
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

  // Long division of the monotonic time: one 8-bit digit per stage.
  localparam int unsigned DIG_W   = 8;
  localparam int unsigned DIG_CNT = 64 / DIG_W;
  localparam int unsigned REM_W   = $clog2(SLEW_DIV);
  localparam int unsigned QW      = 63 - $clog2(SLEW_DIV) + 1;

  // 2^64 split into quotient and remainder by the slew divisor, for wrapped elapsed time.
  localparam logic [64:0]      TWO64    = 65'h1_0000_0000_0000_0000;
  localparam logic [63:0]      Q_WRAP   = 64'(TWO64 / SLEW_DIV);
  localparam logic [REM_W-1:0] WRAP_REM = REM_W'(TWO64 % SLEW_DIV);

  typedef struct packed {
    logic [1:0]         func;
    logic [62:0]        mono;
    logic [32:0]        secs;
    logic [62:0]        setv;
    logic signed [62:0] delta;
  } swc_item_t;

  typedef struct packed {
    swc_item_t        item;
    logic [QW-1:0]    q;
    logic [REM_W-1:0] r;
    logic [62:0]      prod;
  } swc_stage_t;

  typedef struct packed {
    logic [DIG_W-1:0] q;
    logic [REM_W-1:0] r;
  } swc_digit_t;

  // One radix-256 long-division digit by the slew divisor.
  function automatic swc_digit_t div_step(logic [REM_W-1:0] rem, logic [DIG_W-1:0] din);
    logic [REM_W+DIG_W-1:0] v;
    logic [REM_W+DIG_W-1:0] dv;
    swc_digit_t res;
    v = {rem, din};
    res.q = '0;
    for (int b = DIG_W - 1; b >= 0; b--) begin
      dv = (REM_W + DIG_W)'(SLEW_DIV) << b;
      if (v >= dv) begin
        v = v - dv;
        res.q[b] = 1'b1;
      end
    end
    res.r = v[REM_W-1:0];
    return res;
  endfunction

endpackage

// ===== design/swc_mono_div.sv =====
// Elastic pipeline that splits the monotonic time into quotient and remainder by the slew divisor.
module swc_mono_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_stall,
  input  swc_pkg::swc_item_t    up_item,
  output logic                  dn_valid,
  input  logic                  dn_stall,
  output swc_pkg::swc_stage_t   dn_data
);
  import swc_pkg::*;

  localparam int unsigned NSTG = DIG_CNT + 1;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] go;
  swc_stage_t      stg_r   [NSTG];
  swc_stage_t      stg_nxt [NSTG];

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    go[NSTG-1] = !vld_r[NSTG-1] || !dn_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      go[k] = !vld_r[k] || go[k+1];
    end
  end

  always_comb begin
    swc_digit_t  dig;
    logic [63:0] pad;
    stg_nxt[0].item = up_item;
    stg_nxt[0].q    = '0;
    stg_nxt[0].r    = '0;
    stg_nxt[0].prod = '0;
    for (int k = 1; k < NSTG; k++) begin
      pad        = {1'b0, stg_r[k-1].item.mono};
      dig        = div_step(stg_r[k-1].r, pad[63 - DIG_W*(k-1) -: DIG_W]);
      stg_nxt[k] = stg_r[k-1];
      stg_nxt[k].q = QW'({stg_r[k-1].q, dig.q});
      stg_nxt[k].r = dig.r;
    end
    // Seconds to nanoseconds; the product stays below 2^63.
    stg_nxt[1].prod = 63'({30'd0, stg_r[0].item.secs} * {33'd0, NS_PER_SEC});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (go[0]) vld_r[0] <= up_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (go[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG; k++) begin
      if (go[k]) stg_r[k] <= stg_nxt[k];
    end
  end

  assign up_stall = !go[0];
  assign dn_valid = vld_r[NSTG-1];
  assign dn_data  = stg_r[NSTG-1];

endmodule

// ===== design/slewed_wall_clock.sv =====
// Slewed wall clock: staged divide of monotonic time, state update, output register.
//
// Each item carries the current monotonic time in nanoseconds and one of four
// operations: read, init from seconds (ignored once ready), set (steps the clock
// and cancels any slew) and slew (adds a correction applied at 500 ppm). One
// result item comes out per input item: the wall time for reads (zero for the
// other operations, and zero when the 64-bit sum is negative) and the ready
// flag after the operation. The block takes one item per clock cycle and keeps
// doing so while results stall, as long as its pipeline has an empty stage.
// An accepted item lands in an input register, passes eight long-division
// stages that each retire one 8-bit digit of mono_ns / 2000, and then the
// state update writes the output register. That state update keeps the rate
// of one item per cycle, as it computes the next clock state combinationally
// from the registered state. The slew start time is held as quotient and
// remainder by 2000, so the elapsed slew amount is a subtract of stored
// quotients with a small remainder correction; time going backwards wraps in
// 64 bits.
module slewed_wall_clock (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [62:0]        in_mono_ns,
  input  logic [32:0]        in_init_seconds,
  input  logic [62:0]        in_set_time_ns,
  input  logic signed [62:0] in_slew_delta_ns,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [62:0]        out_wall_ns,
  output logic               out_ready_res
);
  import swc_pkg::*;

  swc_item_t  up_item;
  swc_stage_t dn;
  logic       dn_valid;
  logic       dn_stall;
  logic       take;

  // Clock state; the slew start is kept divided by the slew divisor.
  logic [63:0]      base_r,  base_nxt;
  logic [63:0]      pend_r,  pend_nxt;
  logic [QW-1:0]    sq_r,    sq_nxt;
  logic [REM_W-1:0] sr_r,    sr_nxt;
  logic             init_r,  init_nxt;

  logic        out_valid_r;
  logic [62:0] out_wall_r, out_wall_nxt;
  logic        out_ready_r;

  // Elapsed-slew datapath
  logic          borrow;
  logic          kbit;
  logic [QW:0]   dq;
  logic [63:0]   dq_ext;
  logic [63:0]   lim;
  logic          neg;
  logic [63:0]   mag;
  logic [63:0]   clamp;
  logic [63:0]   applied;
  logic [63:0]   mono64;
  logic [63:0]   sum;

  assign up_item.func  = in_func;
  assign up_item.mono  = in_mono_ns;
  assign up_item.secs  = in_init_seconds;
  assign up_item.setv  = in_set_time_ns;
  assign up_item.delta = in_slew_delta_ns;

  swc_mono_div u_mono_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_item  (up_item),
    .dn_valid (dn_valid),
    .dn_stall (dn_stall),
    .dn_data  (dn)
  );

  // Hold the last stage while a finished result waits to be taken.
  assign dn_stall = out_valid_r && out_stall;
  assign take     = dn_valid && !dn_stall;

  always_comb begin
    mono64 = {1'b0, dn.item.mono};

    // floor((mono - start) / 2000) from stored quotients and remainders.
    borrow = dn.r < sr_r;
    dq     = {1'b0, dn.q} - {1'b0, sq_r} - (QW + 1)'(borrow);
    dq_ext = {{(63 - QW){dq[QW]}}, dq};
    // Remainder correction when the elapsed time wraps past 2^64.
    if (dn.r >= sr_r) begin
      kbit = (dn.r - sr_r) >= (REM_W'(SLEW_DIV) - WRAP_REM);
    end else begin
      kbit = (sr_r - dn.r) <= WRAP_REM;
    end
    lim = dq[QW] ? (Q_WRAP + dq_ext + 64'(kbit)) : dq_ext;

    // Clamp to the pending magnitude and give it the pending sign.
    neg     = pend_r[63];
    mag     = neg ? (64'd0 - pend_r) : pend_r;
    clamp   = (lim > mag) ? mag : lim;
    applied = neg ? (64'd0 - clamp) : clamp;

    sum = base_r + mono64 + applied;

    base_nxt     = base_r;
    pend_nxt     = pend_r;
    sq_nxt       = sq_r;
    sr_nxt       = sr_r;
    init_nxt     = init_r;
    out_wall_nxt = '0;

    case (swc_func_t'(dn.item.func))
      FN_READ: begin
        out_wall_nxt = sum[63] ? 63'd0 : sum[62:0];
      end
      FN_INIT: begin
        // Ignore init once the clock is running.
        if (!init_r) begin
          base_nxt = {1'b0, dn.prod} - mono64;
          init_nxt = 1'b1;
        end
      end
      FN_SET: begin
        base_nxt = {1'b0, dn.item.setv} - mono64;
        pend_nxt = '0;
        init_nxt = 1'b1;
      end
      FN_SLEW: begin
        // Fold the applied part into the base, restart the slew from now.
        base_nxt = base_r + applied;
        pend_nxt = pend_r - applied + 64'(dn.item.delta);
        sq_nxt   = dn.q;
        sr_nxt   = dn.r;
      end
      default: begin
        out_wall_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      pend_r      <= '0;
      sq_r        <= '0;
      sr_r        <= '0;
      init_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        base_r <= base_nxt;
        pend_r <= pend_nxt;
        sq_r   <= sq_nxt;
        sr_r   <= sr_nxt;
        init_r <= init_nxt;
      end
      if (!dn_stall) out_valid_r <= dn_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_wall_r  <= out_wall_nxt;
      out_ready_r <= init_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_wall_ns   = out_wall_r;
  assign out_ready_res = out_ready_r;

endmodule

// ===== design/swc_checker.sv =====
// Port-level checker for the slewed wall clock, bound to the top level.
module swc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [62:0] out_wall_ns,
  input logic        out_ready_res
);

  logic seen_ready_r;

  // Track whether a delivered item has already shown the clock ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_ready_r <= 1'b0;
    end else if (out_valid && !out_stall && out_ready_res) begin
      seen_ready_r <= 1'b1;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_ready_r |-> out_ready_res)
    else $error("ready flag dropped after it was set");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the output side can move");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_wall_ns) && $stable(out_ready_res))
    else $error("stalled result item changed");

endmodule

bind slewed_wall_clock swc_checker u_swc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_wall_ns   (out_wall_ns),
  .out_ready_res (out_ready_res)
);

// ===== bench/swc_wall_check.sv =====
// Channel watcher for the slewed wall clock: tracks the clock state and checks every result item.
module swc_wall_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [62:0]        in_mono_ns,
  input  logic [32:0]        in_init_seconds,
  input  logic [62:0]        in_set_time_ns,
  input  logic signed [62:0] in_slew_delta_ns,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [62:0]        out_wall_ns,
  input  logic               out_ready_res,
  output int                 errors,
  output int                 outstanding
);
  import swc_pkg::*;

  // 500 ppm means one ns of correction per 2000 ns of monotonic time.
  localparam logic [63:0] DRIFT_DIV  = 64'd2000;
  localparam logic [63:0] NS_IN_SEC  = 64'd1000000000;

  typedef struct packed {
    logic [62:0] wall;
    logic        ready;
  } reading_t;

  logic [63:0] base_ns;
  logic [63:0] slew_left;
  logic [63:0] slew_t0;
  logic        synced;
  reading_t    due_readings[$];

  // Signed share of the pending correction that has run out by monotonic time now.
  function automatic logic [63:0] slewed_part(logic [63:0] now);
    logic [63:0] span;
    logic [63:0] mag;
    logic        neg;
    if (slew_left == '0) return '0;
    neg  = slew_left[63];
    span = (now - slew_t0) / DRIFT_DIV;
    mag  = neg ? -slew_left : slew_left;
    if (span > mag) span = mag;
    return neg ? -span : span;
  endfunction

  // Apply one item to the tracked clock and return the reading it must produce.
  function automatic reading_t step_clock(swc_func_t fn, logic [62:0] mono, logic [32:0] secs,
                                          logic [62:0] setv, logic signed [62:0] delta);
    logic [63:0] now;
    logic [63:0] sum;
    logic [63:0] done;
    reading_t    r;
    now    = {1'b0, mono};
    r.wall = '0;
    case (fn)
      FN_READ: begin
        sum = base_ns + now + slewed_part(now);
        if (!sum[63]) r.wall = sum[62:0];
      end
      FN_INIT: begin
        if (!synced) begin
          base_ns = {31'd0, secs} * NS_IN_SEC - now;
          synced  = 1'b1;
        end
      end
      FN_SET: begin
        base_ns   = {1'b0, setv} - now;
        slew_left = '0;
        synced    = 1'b1;
      end
      default: begin
        done      = slewed_part(now);
        base_ns   = base_ns + done;
        slew_left = slew_left - done + {delta[62], delta};
        slew_t0   = now;
      end
    endcase
    r.ready = synced;
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      base_ns   = '0;
      slew_left = '0;
      slew_t0   = '0;
      synced    = 1'b0;
      errors    = 0;
      due_readings.delete();
    end else begin
      // Retire the result first; the block's latency keeps it apart from this cycle's input.
      if (out_valid && !out_stall) begin
        if (due_readings.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result item: wall %0d ready %0b", out_wall_ns, out_ready_res);
        end else begin
          want = due_readings.pop_front();
          if (out_wall_ns !== want.wall || out_ready_res !== want.ready) begin
            errors++;
            if (errors <= 10)
              $display("result mismatch: wall exp %0d got %0d, ready exp %0b got %0b",
                       want.wall, out_wall_ns, want.ready, out_ready_res);
          end
        end
      end
      if (in_valid && !in_stall)
        due_readings.push_back(step_clock(swc_func_t'(in_func), in_mono_ns, in_init_seconds,
                                          in_set_time_ns, in_slew_delta_ns));
    end
    outstanding = due_readings.size();
  end

endmodule

// ===== bench/slewed_wall_clock_tb.sv =====
// Top of the slewed wall clock bench: clock, reset, item stimulus, result stalls and verdict.
module slewed_wall_clock_tb;
  import swc_pkg::*;

  // Cycle limit for the whole run, with a wide margin over the slowest correct run.
  localparam int LIMIT = 100000;
  // Cycles to keep watching after the last expected item for stray results.
  localparam int DRAIN = 40;
  localparam int RANDOM_ITEMS = 850;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_func;
  logic [62:0]        in_mono_ns;
  logic [32:0]        in_init_seconds;
  logic [62:0]        in_set_time_ns;
  logic signed [62:0] in_slew_delta_ns;
  logic               out_valid;
  logic               out_stall;
  logic [62:0]        out_wall_ns;
  logic               out_ready_res;

  int          errors;
  int          outstanding;
  int          cycles;
  bit          calm;      // set during stretches where neither side idles
  logic [62:0] mono_now;  // running monotonic time for the random part

  slewed_wall_clock DUT (.*);

  swc_wall_check watch (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle counter: end the run as failed if it never drains.
  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("slewed_wall_clock verification failed");
    $finish;
  end

  // Result side: draw a stall length for every item, then drop stall until one is taken.
  initial begin
    int hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 4);
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  function automatic logic [62:0] noise63();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[62:0];
  endfunction

  function automatic logic [32:0] noise33();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[32:0];
  endfunction

  // Offer one item after a random gap and hold it until the block takes it.
  task automatic offer_item(swc_func_t fn, logic [62:0] mono, logic [32:0] secs,
                            logic [62:0] setv, logic signed [62:0] delta);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= fn;
    in_mono_ns       <= mono;
    in_init_seconds  <= secs;
    in_set_time_ns   <= setv;
    in_slew_delta_ns <= delta;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    int                 pick;
    logic signed [62:0] delta;
    logic [62:0]        setv;
    in_valid         = 1'b0;
    in_func          = FN_READ;
    in_mono_ns       = '0;
    in_init_seconds  = '0;
    in_set_time_ns   = '0;
    in_slew_delta_ns = '0;
    rst_n            = 1'b0;
    calm             = 1'b0;
    mono_now         = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Unused fields carry noise so their bits move too.
    // Read before any init or set: wall is just monotonic time, not ready.
    offer_item(FN_READ, 63'd0, noise33(), noise63(), noise63());
    // Slew before init is legal and arms a correction.
    offer_item(FN_SLEW, 63'd1000, noise33(), noise63(), 63'sd5000000);
    offer_item(FN_READ, 63'd2000000000, noise33(), noise63(), noise63());
    // Init with the largest seconds value: the ns product stays below 2^63.
    offer_item(FN_INIT, 63'd3000000000, 33'h1_FFFF_FFFF, noise63(), noise63());
    // Second init must be ignored.
    offer_item(FN_INIT, 63'd3000000005, 33'd0, noise63(), noise63());
    // Long after the slew: applied part clamps to the full correction.
    offer_item(FN_READ, 63'd4000000000000, noise33(), noise63(), noise63());
    // Step to the largest time, which also cancels the slew.
    offer_item(FN_SET, 63'd5000000000000, noise33(), {63{1'b1}}, noise63());
    offer_item(FN_READ, 63'd5000000000007, noise33(), noise63(), noise63());
    // Two most-negative slews at the same instant stack to a pending -2^63.
    offer_item(FN_SLEW, 63'd6000000000000, noise33(), noise63(), {1'b1, 62'd0});
    offer_item(FN_SLEW, 63'd6000000000000, noise33(), noise63(), {1'b1, 62'd0});
    offer_item(FN_READ, {63{1'b1}}, noise33(), noise63(), noise63());
    // Monotonic time going back: elapsed wraps, correction applies in full.
    offer_item(FN_READ, 63'd1000, noise33(), noise63(), noise63());
    // Largest positive slew folds the running part into the base.
    offer_item(FN_SLEW, 63'd6000000000010, noise33(), noise63(), {1'b0, {62{1'b1}}});
    // Set to zero, then read earlier than the set: the sum goes negative and reads zero.
    offer_item(FN_SET, 63'd1000000, noise33(), 63'd0, noise63());
    offer_item(FN_READ, 63'd10, noise33(), noise63(), noise63());
    offer_item(FN_READ, 63'd1000000, noise33(), noise63(), noise63());
    // Tiny negative slew, then a read just before its start.
    offer_item(FN_SLEW, 63'd2000000, noise33(), noise63(), -63'sd1);
    offer_item(FN_READ, 63'd1999999, noise33(), noise63(), noise63());
    offer_item(FN_SLEW, 63'd3000000, noise33(), noise63(), 63'sd0);
    offer_item(FN_READ, 63'd4000000, noise33(), noise63(), noise63());
    mono_now = 63'd4000000;

    // Random part: mostly forward time with slews in flight, some jumps and full-range noise.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i % 160) < 30;
      if ($urandom_range(0, 39) == 0)
        mono_now = noise63();
      else if ($urandom_range(0, 4) != 0)
        mono_now = mono_now + (63'($urandom) << $urandom_range(0, 20));

      if ($urandom_range(0, 7) == 0) begin
        delta = noise63();
      end else begin
        delta = 63'($urandom) << $urandom_range(0, 16);
        if ($urandom_range(0, 1) == 1) delta = -delta;
      end
      setv = ($urandom_range(0, 1) == 1) ? noise63() : mono_now + 63'($urandom);

      pick = $urandom_range(0, 99);
      if (pick < 40)
        offer_item(FN_READ, mono_now, noise33(), noise63(), delta);
      else if (pick < 65)
        offer_item(FN_SLEW, mono_now, noise33(), setv, delta);
      else if (pick < 85)
        offer_item(FN_SET, mono_now, noise33(), setv, delta);
      else
        offer_item(FN_INIT, mono_now, noise33(), setv, delta);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain: wait for every expected item, then watch a while for strays.
    calm = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("slewed_wall_clock verification clean");
    else
      $display("slewed_wall_clock verification failed");
    $finish;
  end

endmodule
